/* design/sd_card_spi_host_sequencer_macros.svh */
// Assertion helpers for the SD card SPI host sequencer
`ifndef SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH

// Check an implication on every clock edge outside reset
`define SDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the cycle after the antecedent
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sds_pkg.sv */
`timescale 1ns / 1ps

package sds_pkg;

    localparam int BLOCK_BYTES_DEF        = 512;
    localparam int SYNC_BYTES_DEF         = 80;
    localparam int R1_POLL_LIMIT_DEF      = 8;
    localparam int IDLE_RETRY_LIMIT_DEF   = 10;
    localparam int OPCOND_RETRY_LIMIT_DEF = 100;

    localparam logic [3:0] STEP_DELAY = 4'd10;

    typedef enum logic [1:0] {
        MODE_REQUEST  = 2'd0,
        MODE_EXCHANGE = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_BLOCK_ADDRESS   = 2'd0,
        REG_DATA_WAIT_LIMIT = 2'd1,
        REG_RESET_PULSE_MS  = 2'd2,
        REG_POWER_SETTLE_MS = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        C_CMD0   = 3'd0,
        C_CMD8   = 3'd1,
        C_CMD55  = 3'd2,
        C_ACMD41 = 3'd3,
        C_CMD58  = 3'd4,
        C_CMD17  = 3'd5,
        C_CMD24  = 3'd6,
        C_NONE   = 3'd7
    } cmd_t;

    localparam logic [7:0] IDLE_BYTE   = 8'hff;
    localparam logic [7:0] DATA_TOKEN  = 8'hfe;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_NONE    = 8'h01;
    localparam logic [7:0] ECHO_BYTE   = 8'haa;
    localparam logic [7:0] RESP_MASK   = 8'h1f;
    localparam logic [7:0] RESP_ACCEPT = 8'h05;
    localparam logic [7:0] R1_IDLE     = 8'h01;

    function automatic logic [7:0] lead_byte(input cmd_t c);
        case (c)
            C_CMD0:   lead_byte = 8'h40;
            C_CMD8:   lead_byte = 8'h48;
            C_CMD55:  lead_byte = 8'h77;
            C_ACMD41: lead_byte = 8'h69;
            C_CMD58:  lead_byte = 8'h7a;
            C_CMD17:  lead_byte = 8'h51;
            C_CMD24:  lead_byte = 8'h58;
            default:  lead_byte = 8'h40;
        endcase
    endfunction

    // byte k of the six-byte command frame
    function automatic logic [7:0] command_byte(input cmd_t c, input logic [2:0] k,
                                                input logic [31:0] addr);
        logic [31:0] arg;
        arg = 32'd0;
        if (c == C_CMD8)
            arg = 32'h0000_01aa;
        else if (c == C_CMD17 || c == C_CMD24)
            arg = addr;
        case (k)
            3'd0:    command_byte = lead_byte(c);
            3'd1:    command_byte = arg[31:24];
            3'd2:    command_byte = arg[23:16];
            3'd3:    command_byte = arg[15:8];
            3'd4:    command_byte = arg[7:0];
            default: command_byte = (c == C_CMD0) ? CRC_CMD0 :
                                    ((c == C_CMD8) ? CRC_CMD8 : CRC_NONE);
        endcase
    endfunction

endpackage

/* design/sd_card_spi_host_sequencer.sv */
`timescale 1ns / 1ps

// SD card SPI-mode host sequencer.
// Input channel (valid/ready): one event per transaction; mode selects an
// operation request (op), a finished SPI byte exchange (miso_byte, and
// write_byte as the next block byte) or a millisecond tick.
// Output channel (valid/ready): exactly one result per event: the next byte
// to shift (mosi_byte/send_valid), pin levels, block read data, byte_taken,
// done_res/status and the last R1 response.
// Config channel (valid/ready): index 0..3 writes block_address,
// data_wait_limit, reset_pulse_ms, power_settle_ms; always ready.
// A result is registered, valid in the cycle after its event is accepted.
// Throughput: one event per cycle; the state update is one pass of
// combinational logic from the state registers into the result register.
// When the receiver stalls, the result register holds and a new event is
// accepted only if the result register is empty or is taken that cycle.
// Reset: idle, card deselected, holder reset low, power on, R1 reads 0xff,
// registers at 2048, 1562, 75 and 250.

`include "sd_card_spi_host_sequencer_macros.svh"

module sd_card_spi_host_sequencer #(
    parameter int BLOCK_BYTES        = sds_pkg::BLOCK_BYTES_DEF,
    parameter int SYNC_BYTES         = sds_pkg::SYNC_BYTES_DEF,
    parameter int R1_POLL_LIMIT      = sds_pkg::R1_POLL_LIMIT_DEF,
    parameter int IDLE_RETRY_LIMIT   = sds_pkg::IDLE_RETRY_LIMIT_DEF,
    parameter int OPCOND_RETRY_LIMIT = sds_pkg::OPCOND_RETRY_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [1:0]  op,
    input  logic [7:0]  miso_byte,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  mosi_byte,
    output logic        send_valid,
    output logic        chip_select,
    output logic        card_reset,
    output logic        card_power,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        byte_taken,
    output logic        done_res,
    output logic        status,
    output logic [7:0]  r1_response,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_HOLD, PH_SETTLE, PH_PRESYNC, PH_SYNC, PH_OPEN0, PH_OPEN1,
        PH_CMD, PH_R1, PH_TAIL, PH_TOKEN, PH_RDATA, PH_WTOKEN, PH_WDATA,
        PH_CRC, PH_WRESP, PH_BUSY, PH_CLOSE0, PH_CLOSE1, PH_OPDELAY
    } phase_t;

    localparam int BW = $clog2(BLOCK_BYTES + SYNC_BYTES + 2);
    localparam int PW = 12;
    localparam int RW = 7;
    localparam logic [BW-1:0] BLOCK_LAST = BW'(BLOCK_BYTES - 1);
    localparam logic [BW-1:0] SYNC_END   = BW'(SYNC_BYTES + 1);
    localparam logic [PW-1:0] R1_LIMIT   = PW'(R1_POLL_LIMIT);
    localparam logic [RW-1:0] IDLE_LIM   = RW'(IDLE_RETRY_LIMIT);
    localparam logic [RW-1:0] OPC_LIM    = RW'(OPCOND_RETRY_LIMIT);

    logic [31:0]    addr_reg;
    logic [11:0]    wait_lim_reg;
    logic [7:0]     pulse_reg;
    logic [9:0]     settle_reg;

    phase_t         phase_reg, phase_next;
    logic [1:0]     cur_op_reg, cur_op_next;
    logic [BW-1:0]  idx_reg, idx_next;
    logic [PW-1:0]  poll_reg, poll_next;
    logic [RW-1:0]  retry_reg, retry_next;
    logic [9:0]     tick_reg, tick_next;
    logic [7:0]     r1_reg, r1_next;
    logic [7:0]     resp_reg, resp_next;
    sds_pkg::cmd_t  cmd_reg, cmd_next;
    logic           cs_reg, cs_next, rst_pin_reg, rst_pin_next, pwr_reg, pwr_next;

    logic [7:0]     o_mosi, o_read;
    logic           o_send, o_rvalid, o_taken, o_done, o_status;

    logic           valid_reg;
    logic           accept;
    logic [11:0]    wlim;
    logic [9:0]     target;
    logic           tick_wait;
    logic [PW-1:0]  poll_inc;
    logic [BW-1:0]  idx_inc;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign cfg_ready = 1'b1;
    assign wlim      = (wait_lim_reg == 12'd0) ? 12'd1 : wait_lim_reg;
    assign poll_inc  = poll_reg + PW'(1);
    assign idx_inc   = idx_reg + BW'(1);

    always_comb
    begin
        tick_wait = 1'b1;
        case (phase_reg)
            PH_HOLD:    target = (pulse_reg == 8'd0) ? 10'd1 : {2'b00, pulse_reg};
            PH_SETTLE:  target = (settle_reg == 10'd0) ? 10'd1 : settle_reg;
            PH_PRESYNC: target = {6'd0, sds_pkg::STEP_DELAY};
            PH_OPDELAY: target = {6'd0, sds_pkg::STEP_DELAY};
            default:
            begin
                target    = 10'd1;
                tick_wait = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        logic close_f, begin_f, fin;
        sds_pkg::cmd_t begin_id;
        phase_t p;
        close_f  = 1'b0;
        begin_f  = 1'b0;
        fin      = 1'b0;
        begin_id = sds_pkg::C_CMD0;
        p        = phase_reg;

        phase_next   = phase_reg;
        cur_op_next  = cur_op_reg;
        idx_next     = idx_reg;
        poll_next    = poll_reg;
        retry_next   = retry_reg;
        tick_next    = tick_reg;
        r1_next      = r1_reg;
        resp_next    = resp_reg;
        cmd_next     = cmd_reg;
        cs_next      = cs_reg;
        rst_pin_next = rst_pin_reg;
        pwr_next     = pwr_reg;
        o_mosi   = 8'd0;
        o_send   = 1'b0;
        o_read   = 8'd0;
        o_rvalid = 1'b0;
        o_taken  = 1'b0;
        o_done   = 1'b0;
        o_status = 1'b0;

        case (sds_pkg::mode_t'(mode))
            sds_pkg::MODE_REQUEST:
            begin
                if (p == PH_IDLE && sds_pkg::op_t'(op) != sds_pkg::OP_NONE)
                begin
                    cur_op_next = op;
                    if (sds_pkg::op_t'(op) == sds_pkg::OP_INIT)
                    begin
                        cs_next      = 1'b0;
                        rst_pin_next = 1'b1;
                        pwr_next     = 1'b0;
                        phase_next   = PH_HOLD;
                        tick_next    = 10'd0;
                    end
                    else
                    begin
                        begin_f  = 1'b1;
                        begin_id = (sds_pkg::op_t'(op) == sds_pkg::OP_READ) ?
                                   sds_pkg::C_CMD17 : sds_pkg::C_CMD24;
                    end
                end
            end
            sds_pkg::MODE_TICK:
            begin
                if (tick_wait)
                begin
                    if (tick_reg + 10'd1 < target)
                        tick_next = tick_reg + 10'd1;
                    else
                    begin
                        tick_next = 10'd0;
                        case (p)
                            PH_HOLD:
                            begin
                                rst_pin_next = 1'b0;
                                pwr_next     = 1'b1;
                                phase_next   = PH_SETTLE;
                            end
                            PH_SETTLE:  phase_next = PH_PRESYNC;
                            PH_PRESYNC:
                            begin
                                phase_next = PH_SYNC;
                                idx_next   = '0;
                                o_mosi     = sds_pkg::IDLE_BYTE;
                                o_send     = 1'b1;
                            end
                            default:
                            begin
                                // decide after the op-cond delay
                                begin_f = 1'b1;
                                if (r1_reg == 8'd0)
                                    begin_id = sds_pkg::C_CMD58;
                                else if (retry_reg >= OPC_LIM)
                                begin
                                    begin_f = 1'b0;
                                    fin     = 1'b1;
                                    o_status = 1'b1;
                                end
                                else
                                begin
                                    retry_next = retry_reg + RW'(1);
                                    begin_id   = sds_pkg::C_CMD55;
                                end
                            end
                        endcase
                    end
                end
            end
            sds_pkg::MODE_EXCHANGE:
            begin
                case (p)
                    PH_SYNC:
                    begin
                        idx_next = idx_inc;
                        if (idx_inc < SYNC_END)
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                        else
                        begin
                            retry_next = '0;
                            begin_f    = 1'b1;
                            begin_id   = sds_pkg::C_CMD0;
                        end
                    end
                    PH_OPEN0:
                    begin
                        cs_next    = 1'b1;
                        phase_next = PH_OPEN1;
                        o_mosi     = sds_pkg::IDLE_BYTE;
                        o_send     = 1'b1;
                    end
                    PH_OPEN1:
                    begin
                        phase_next = PH_CMD;
                        idx_next   = '0;
                        o_mosi     = sds_pkg::command_byte(cmd_reg, 3'd0, addr_reg);
                        o_send     = 1'b1;
                    end
                    PH_CMD:
                    begin
                        idx_next = idx_inc;
                        o_send   = 1'b1;
                        if (idx_inc < BW'(6))
                            o_mosi = sds_pkg::command_byte(cmd_reg, idx_inc[2:0], addr_reg);
                        else
                        begin
                            phase_next = PH_R1;
                            poll_next  = '0;
                            o_mosi     = sds_pkg::IDLE_BYTE;
                        end
                    end
                    PH_R1:
                    begin
                        poll_next = poll_inc;
                        if (miso_byte != sds_pkg::IDLE_BYTE || poll_inc >= R1_LIMIT)
                        begin
                            r1_next   = miso_byte;
                            resp_next = miso_byte;
                            o_send    = 1'b1;
                            o_mosi    = sds_pkg::IDLE_BYTE;
                            if ((cmd_reg == sds_pkg::C_CMD8 || cmd_reg == sds_pkg::C_CMD58)
                                && miso_byte <= 8'd1)
                            begin
                                phase_next = PH_TAIL;
                                idx_next   = '0;
                            end
                            else if (cmd_reg == sds_pkg::C_CMD17
                                     && miso_byte != sds_pkg::IDLE_BYTE)
                            begin
                                phase_next = PH_TOKEN;
                                poll_next  = '0;
                            end
                            else if (cmd_reg == sds_pkg::C_CMD24 && miso_byte == 8'd0)
                            begin
                                phase_next = PH_WTOKEN;
                                o_mosi     = sds_pkg::DATA_TOKEN;
                            end
                            else
                                phase_next = PH_CLOSE0;
                        end
                        else
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                    end
                    PH_TAIL:
                    begin
                        resp_next = miso_byte;
                        idx_next  = idx_inc;
                        if (idx_inc < BW'(4))
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                        else
                            close_f = 1'b1;
                    end
                    PH_TOKEN:
                    begin
                        poll_next = poll_inc;
                        resp_next = miso_byte;
                        if (miso_byte == sds_pkg::DATA_TOKEN)
                        begin
                            phase_next = PH_RDATA;
                            idx_next   = '0;
                            o_mosi     = sds_pkg::IDLE_BYTE;
                            o_send     = 1'b1;
                        end
                        else if (miso_byte != sds_pkg::IDLE_BYTE || poll_inc >= wlim)
                            close_f = 1'b1;
                        else
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                    end
                    PH_RDATA:
                    begin
                        o_read   = miso_byte;
                        o_rvalid = 1'b1;
                        o_mosi   = sds_pkg::IDLE_BYTE;
                        o_send   = 1'b1;
                        if (idx_reg < BLOCK_LAST)
                            idx_next = idx_inc;
                        else
                        begin
                            phase_next = PH_CRC;
                            idx_next   = '0;
                        end
                    end
                    PH_WTOKEN:
                    begin
                        phase_next = PH_WDATA;
                        idx_next   = '0;
                        o_mosi     = write_byte;
                        o_send     = 1'b1;
                        o_taken    = 1'b1;
                    end
                    PH_WDATA:
                    begin
                        o_send = 1'b1;
                        if (idx_reg < BLOCK_LAST)
                        begin
                            idx_next = idx_inc;
                            o_mosi   = write_byte;
                            o_taken  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CRC;
                            idx_next   = '0;
                            o_mosi     = sds_pkg::IDLE_BYTE;
                        end
                    end
                    PH_CRC:
                    begin
                        idx_next = idx_inc;
                        if (idx_inc < BW'(2))
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                        else if (sds_pkg::op_t'(cur_op_reg) == sds_pkg::OP_WRITE)
                        begin
                            phase_next = PH_WRESP;
                            poll_next  = '0;
                            o_mosi     = sds_pkg::IDLE_BYTE;
                            o_send     = 1'b1;
                        end
                        else
                            close_f = 1'b1;
                    end
                    PH_WRESP:
                    begin
                        poll_next = poll_inc;
                        resp_next = miso_byte;
                        if (miso_byte != sds_pkg::IDLE_BYTE)
                        begin
                            if ((miso_byte & sds_pkg::RESP_MASK) == sds_pkg::RESP_ACCEPT)
                            begin
                                phase_next = PH_BUSY;
                                poll_next  = '0;
                                o_mosi     = sds_pkg::IDLE_BYTE;
                                o_send     = 1'b1;
                            end
                            else
                                close_f = 1'b1;
                        end
                        else if (poll_inc >= wlim)
                            close_f = 1'b1;
                        else
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                    end
                    PH_BUSY:
                    begin
                        poll_next = poll_inc;
                        if (miso_byte != 8'd0 || poll_inc >= wlim)
                            close_f = 1'b1;
                        else
                        begin
                            o_mosi = sds_pkg::IDLE_BYTE;
                            o_send = 1'b1;
                        end
                    end
                    PH_CLOSE0:
                    begin
                        cs_next    = 1'b0;
                        phase_next = PH_CLOSE1;
                        o_mosi     = sds_pkg::IDLE_BYTE;
                        o_send     = 1'b1;
                    end
                    PH_CLOSE1:
                    begin
                        case (cmd_reg)
                            sds_pkg::C_CMD0:
                            begin
                                begin_f = 1'b1;
                                if (r1_reg == sds_pkg::R1_IDLE)
                                begin
                                    retry_next = '0;
                                    begin_id   = sds_pkg::C_CMD8;
                                end
                                else if (retry_reg >= IDLE_LIM)
                                begin
                                    begin_f  = 1'b0;
                                    fin      = 1'b1;
                                    o_status = 1'b1;
                                end
                                else
                                begin
                                    retry_next = retry_reg + RW'(1);
                                    begin_id   = sds_pkg::C_CMD0;
                                end
                            end
                            sds_pkg::C_CMD8:
                            begin
                                if (r1_reg == sds_pkg::R1_IDLE && resp_reg == sds_pkg::ECHO_BYTE)
                                begin
                                    retry_next = '0;
                                    begin_f    = 1'b1;
                                    begin_id   = sds_pkg::C_CMD55;
                                end
                                else
                                begin
                                    fin      = 1'b1;
                                    o_status = 1'b1;
                                end
                            end
                            sds_pkg::C_CMD55:
                            begin
                                if (r1_reg < 8'd2)
                                begin
                                    begin_f  = 1'b1;
                                    begin_id = sds_pkg::C_ACMD41;
                                end
                                else
                                begin
                                    phase_next = PH_OPDELAY;
                                    tick_next  = 10'd0;
                                end
                            end
                            sds_pkg::C_ACMD41:
                            begin
                                phase_next = PH_OPDELAY;
                                tick_next  = 10'd0;
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (begin_f)
        begin
            cmd_next   = begin_id;
            phase_next = PH_OPEN0;
            o_mosi     = sds_pkg::IDLE_BYTE;
            o_send     = 1'b1;
        end
        if (close_f)
        begin
            phase_next = PH_CLOSE0;
            o_mosi     = sds_pkg::IDLE_BYTE;
            o_send     = 1'b1;
        end
        if (fin)
        begin
            phase_next = PH_IDLE;
            o_done     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= 32'd2048;
            wait_lim_reg <= 12'd1562;
            pulse_reg    <= 8'd75;
            settle_reg   <= 10'd250;
            phase_reg    <= PH_IDLE;
            cur_op_reg   <= 2'd0;
            idx_reg      <= '0;
            poll_reg     <= '0;
            retry_reg    <= '0;
            tick_reg     <= 10'd0;
            r1_reg       <= 8'hff;
            resp_reg     <= 8'd0;
            cmd_reg      <= sds_pkg::C_CMD0;
            cs_reg       <= 1'b0;
            rst_pin_reg  <= 1'b0;
            pwr_reg      <= 1'b1;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (sds_pkg::reg_index_t'(cfg_index))
                    sds_pkg::REG_BLOCK_ADDRESS:   addr_reg     <= cfg_data;
                    sds_pkg::REG_DATA_WAIT_LIMIT: wait_lim_reg <= cfg_data[11:0];
                    sds_pkg::REG_RESET_PULSE_MS:  pulse_reg    <= cfg_data[7:0];
                    sds_pkg::REG_POWER_SETTLE_MS: settle_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                cur_op_reg  <= cur_op_next;
                idx_reg     <= idx_next;
                poll_reg    <= poll_next;
                retry_reg   <= retry_next;
                tick_reg    <= tick_next;
                r1_reg      <= r1_next;
                resp_reg    <= resp_next;
                cmd_reg     <= cmd_next;
                cs_reg      <= cs_next;
                rst_pin_reg <= rst_pin_next;
                pwr_reg     <= pwr_next;
                valid_reg   <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // result payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mosi_byte  <= o_mosi;
            send_valid <= o_send;
            read_byte  <= o_read;
            read_valid <= o_rvalid;
            byte_taken <= o_taken;
            done_res   <= o_done;
            status     <= o_status;
        end
    end

    assign chip_select = cs_reg;
    assign card_reset  = rst_pin_reg;
    assign card_power  = pwr_reg;
    assign r1_response = r1_reg;

    `SDS_ASSERT_IMPL(a_status_with_done, out_valid && status, done_res,
                     "status set without done")
    `SDS_ASSERT_IMPL(a_idle_on_done, out_valid && done_res, phase_reg == PH_IDLE,
                     "done while not idle")
    `SDS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid,
                     "result dropped while stalled")
    `SDS_ASSERT_IMPL(a_read_sends, out_valid && read_valid, send_valid,
                     "read byte without next exchange")

endmodule

/* bench/sds_checker.sv */
`timescale 1ns / 1ps

module sds_checker
    import sds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [1:0]  op,
    input  logic [7:0]  miso_byte,
    input  logic [7:0]  write_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  mosi_byte,
    input  logic        send_valid,
    input  logic        chip_select,
    input  logic        card_reset,
    input  logic        card_power,
    input  logic [7:0]  read_byte,
    input  logic        read_valid,
    input  logic        byte_taken,
    input  logic        done_res,
    input  logic        status,
    input  logic [7:0]  r1_response,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output logic        at_rest,
    output logic        wants_tick,
    output logic [7:0]  card_hint
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_HOLD, ST_SETTLE, ST_PRESYNC, ST_SYNC, ST_OPEN0, ST_OPEN1,
        ST_CMD, ST_R1, ST_TAIL, ST_TOKEN, ST_RDATA, ST_WTOKEN, ST_WDATA,
        ST_CRC, ST_WRESP, ST_BUSY, ST_CLOSE0, ST_CLOSE1, ST_OPDELAY
    } seq_state_t;

    typedef struct packed {
        logic [7:0] mosi;
        logic       send;
        logic       cs;
        logic       rst;
        logic       pwr;
        logic [7:0] rd;
        logic       rv;
        logic       taken;
        logic       done;
        logic       err;
        logic [7:0] r1;
    } card_result_t;

    // sequencer copy
    seq_state_t   stg;
    op_t          cur_op;
    cmd_t         cmd;
    int           idx, polls, tries, ticks;
    logic [7:0]   r1, resp;
    logic         cs, rst_pin, pwr;
    logic [31:0]  addr;
    logic [11:0]  wlim;
    logic [7:0]   pulse;
    logic [9:0]   settle;
    card_result_t nx;

    card_result_t awaited_results[$];
    int           errs;

    task automatic emit(input logic [7:0] b);
        nx.mosi = b;
        nx.send = 1'b1;
    endtask

    task automatic open_frame(input cmd_t c);
        cmd = c;
        stg = ST_OPEN0;
        emit(IDLE_BYTE);
    endtask

    task automatic close_frame();
        stg = ST_CLOSE0;
        emit(IDLE_BYTE);
    endtask

    task automatic finish_op(input logic e);
        stg = ST_IDLE;
        nx.done = 1'b1;
        nx.err = e;
    endtask

    function automatic int poll_limit();
        return (wlim == 0) ? 1 : int'(wlim);
    endfunction

    function automatic logic [7:0] frame_byte(input int k);
        logic [31:0] arg;
        arg = 32'd0;
        if (cmd == C_CMD8)
            arg = 32'h0000_01aa;
        else if (cmd == C_CMD17 || cmd == C_CMD24)
            arg = addr;
        if (k == 0)
        begin
            case (cmd)
                C_CMD8:   return 8'h48;
                C_CMD55:  return 8'h77;
                C_ACMD41: return 8'h69;
                C_CMD58:  return 8'h7a;
                C_CMD17:  return 8'h51;
                C_CMD24:  return 8'h58;
                default:  return 8'h40;
            endcase
        end
        if (k >= 5)
            return (cmd == C_CMD0) ? CRC_CMD0 : ((cmd == C_CMD8) ? CRC_CMD8 : CRC_NONE);
        return arg[8*(4-k) +: 8];
    endfunction

    task automatic opcond_decide();
        if (r1 == 8'h00)
            open_frame(C_CMD58);
        else if (tries >= OPCOND_RETRY_LIMIT_DEF)
            finish_op(1'b1);
        else
        begin
            tries++;
            open_frame(C_CMD55);
        end
    endtask

    task automatic frame_done();
        case (cmd)
            C_CMD0:
                if (r1 == R1_IDLE)
                begin
                    tries = 0;
                    open_frame(C_CMD8);
                end
                else if (tries >= IDLE_RETRY_LIMIT_DEF)
                    finish_op(1'b1);
                else
                begin
                    tries++;
                    open_frame(C_CMD0);
                end
            C_CMD8:
                if (r1 == R1_IDLE && resp == ECHO_BYTE)
                begin
                    tries = 0;
                    open_frame(C_CMD55);
                end
                else
                    finish_op(1'b1);
            C_CMD55:
                if (r1 < 2)
                    open_frame(C_ACMD41);
                else
                begin
                    stg = ST_OPDELAY;
                    ticks = 0;
                end
            C_ACMD41:
            begin
                stg = ST_OPDELAY;
                ticks = 0;
            end
            default:
                finish_op(1'b0);
        endcase
    endtask

    task automatic after_r1();
        if ((cmd == C_CMD8 || cmd == C_CMD58) && r1 <= 1)
        begin
            stg = ST_TAIL;
            idx = 0;
            emit(IDLE_BYTE);
        end
        else if (cmd == C_CMD17 && r1 != IDLE_BYTE)
        begin
            stg = ST_TOKEN;
            polls = 0;
            emit(IDLE_BYTE);
        end
        else if (cmd == C_CMD24 && r1 == 8'h00)
        begin
            stg = ST_WTOKEN;
            emit(DATA_TOKEN);
        end
        else
            close_frame();
    endtask

    task automatic on_exchange(input logic [7:0] mi, input logic [7:0] wb);
        case (stg)
            ST_SYNC:
            begin
                idx++;
                if (idx < SYNC_BYTES_DEF + 1)
                    emit(IDLE_BYTE);
                else
                begin
                    tries = 0;
                    open_frame(C_CMD0);
                end
            end
            ST_OPEN0:
            begin
                cs = 1'b1;
                stg = ST_OPEN1;
                emit(IDLE_BYTE);
            end
            ST_OPEN1:
            begin
                stg = ST_CMD;
                idx = 0;
                emit(frame_byte(0));
            end
            ST_CMD:
            begin
                idx++;
                if (idx < 6)
                    emit(frame_byte(idx));
                else
                begin
                    stg = ST_R1;
                    polls = 0;
                    emit(IDLE_BYTE);
                end
            end
            ST_R1:
            begin
                polls++;
                if (mi != IDLE_BYTE || polls >= R1_POLL_LIMIT_DEF)
                begin
                    r1 = mi;
                    resp = mi;
                    after_r1();
                end
                else
                    emit(IDLE_BYTE);
            end
            ST_TAIL:
            begin
                resp = mi;
                idx++;
                if (idx < 4)
                    emit(IDLE_BYTE);
                else
                    close_frame();
            end
            ST_TOKEN:
            begin
                polls++;
                resp = mi;
                if (mi == DATA_TOKEN)
                begin
                    stg = ST_RDATA;
                    idx = 0;
                    emit(IDLE_BYTE);
                end
                else if (mi != IDLE_BYTE || polls >= poll_limit())
                    close_frame();
                else
                    emit(IDLE_BYTE);
            end
            ST_RDATA:
            begin
                nx.rd = mi;
                nx.rv = 1'b1;
                if (idx + 1 < BLOCK_BYTES_DEF)
                    idx++;
                else
                begin
                    stg = ST_CRC;
                    idx = 0;
                end
                emit(IDLE_BYTE);
            end
            ST_WTOKEN:
            begin
                stg = ST_WDATA;
                idx = 0;
                emit(wb);
                nx.taken = 1'b1;
            end
            ST_WDATA:
                if (idx + 1 < BLOCK_BYTES_DEF)
                begin
                    idx++;
                    emit(wb);
                    nx.taken = 1'b1;
                end
                else
                begin
                    stg = ST_CRC;
                    idx = 0;
                    emit(IDLE_BYTE);
                end
            ST_CRC:
            begin
                idx++;
                if (idx < 2)
                    emit(IDLE_BYTE);
                else if (cur_op == OP_WRITE)
                begin
                    stg = ST_WRESP;
                    polls = 0;
                    emit(IDLE_BYTE);
                end
                else
                    close_frame();
            end
            ST_WRESP:
            begin
                polls++;
                resp = mi;
                if (mi != IDLE_BYTE)
                begin
                    if ((mi & RESP_MASK) == RESP_ACCEPT)
                    begin
                        stg = ST_BUSY;
                        polls = 0;
                        emit(IDLE_BYTE);
                    end
                    else
                        close_frame();
                end
                else if (polls >= poll_limit())
                    close_frame();
                else
                    emit(IDLE_BYTE);
            end
            ST_BUSY:
            begin
                polls++;
                if (mi != 8'h00 || polls >= poll_limit())
                    close_frame();
                else
                    emit(IDLE_BYTE);
            end
            ST_CLOSE0:
            begin
                cs = 1'b0;
                stg = ST_CLOSE1;
                emit(IDLE_BYTE);
            end
            ST_CLOSE1:
                frame_done();
            default: ;
        endcase
    endtask

    task automatic on_tick();
        int target;
        case (stg)
            ST_HOLD:    target = (pulse == 0) ? 1 : int'(pulse);
            ST_SETTLE:  target = (settle == 0) ? 1 : int'(settle);
            ST_PRESYNC,
            ST_OPDELAY: target = int'(STEP_DELAY);
            default:    return;
        endcase
        ticks++;
        if (ticks < target)
            return;
        ticks = 0;
        case (stg)
            ST_HOLD:
            begin
                rst_pin = 1'b0;
                pwr = 1'b1;
                stg = ST_SETTLE;
            end
            ST_SETTLE:
                stg = ST_PRESYNC;
            ST_PRESYNC:
            begin
                stg = ST_SYNC;
                idx = 0;
                emit(IDLE_BYTE);
            end
            default:
                opcond_decide();
        endcase
    endtask

    task automatic step_card_sequencer(input logic [1:0] m, input logic [1:0] o,
                                       input logic [7:0] mi, input logic [7:0] wb);
        nx = '0;
        case (m)
            MODE_REQUEST:
                if (stg == ST_IDLE && o != OP_NONE)
                begin
                    cur_op = op_t'(o);
                    if (o == OP_INIT)
                    begin
                        cs = 1'b0;
                        rst_pin = 1'b1;
                        pwr = 1'b0;
                        stg = ST_HOLD;
                        ticks = 0;
                    end
                    else
                        open_frame(o == OP_READ ? C_CMD17 : C_CMD24);
                end
            MODE_EXCHANGE:
                on_exchange(mi, wb);
            MODE_TICK:
                on_tick();
            default: ;
        endcase
        nx.cs = cs;
        nx.rst = rst_pin;
        nx.pwr = pwr;
        nx.r1 = r1;
    endtask

    task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, nm, want, got);
            errs++;
        end
    endtask

    always @(posedge clk)
    begin
        card_result_t got, want;
        if (!rst_n)
        begin
            stg = ST_IDLE;
            cur_op = OP_INIT;
            cmd = C_CMD0;
            idx = 0;
            polls = 0;
            tries = 0;
            ticks = 0;
            r1 = 8'hff;
            resp = 8'h00;
            cs = 1'b0;
            rst_pin = 1'b0;
            pwr = 1'b1;
            addr = 32'd2048;
            wlim = 12'd1562;
            pulse = 8'd75;
            settle = 10'd250;
            errs = 0;
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{mosi_byte, send_valid, chip_select, card_reset, card_power,
                        read_byte, read_valid, byte_taken, done_res, status, r1_response};
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected none, actual %h",
                             $time, got);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("mosi_byte", want.mosi, got.mosi);
                    check_field("send_valid", want.send, got.send);
                    check_field("chip_select", want.cs, got.cs);
                    check_field("card_reset", want.rst, got.rst);
                    check_field("card_power", want.pwr, got.pwr);
                    check_field("read_byte", want.rd, got.rd);
                    check_field("read_valid", want.rv, got.rv);
                    check_field("byte_taken", want.taken, got.taken);
                    check_field("done_res", want.done, got.done);
                    check_field("status", want.err, got.err);
                    check_field("r1_response", want.r1, got.r1);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLOCK_ADDRESS:   addr = cfg_data;
                    REG_DATA_WAIT_LIMIT: wlim = cfg_data[11:0];
                    REG_RESET_PULSE_MS:  pulse = cfg_data[7:0];
                    default:             settle = cfg_data[9:0];
                endcase
            end
            if (in_valid && in_ready)
            begin
                step_card_sequencer(mode, op, miso_byte, write_byte);
                awaited_results.push_back(nx);
            end
        end
        fail_count <= errs;
        pending <= awaited_results.size();
        at_rest <= (stg == ST_IDLE);
        wants_tick <= (stg == ST_HOLD || stg == ST_SETTLE || stg == ST_PRESYNC ||
                       stg == ST_OPDELAY);
        // what a well-behaved card would answer next
        case (stg)
            ST_R1:
                if (cmd == C_ACMD41)
                    card_hint <= ($urandom_range(0, 3) == 0) ? 8'h00 : R1_IDLE;
                else if (cmd == C_CMD0 || cmd == C_CMD8 || cmd == C_CMD55)
                    card_hint <= R1_IDLE;
                else
                    card_hint <= 8'h00;
            ST_TAIL:  card_hint <= ECHO_BYTE;
            ST_TOKEN: card_hint <= DATA_TOKEN;
            ST_WRESP: card_hint <= 8'he5;
            ST_BUSY:  card_hint <= 8'h00;
            ST_RDATA: card_hint <= 8'($urandom);
            default:  card_hint <= IDLE_BYTE;
        endcase
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import sds_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = MODE_NONE;
    logic [1:0]  op = OP_NONE;
    logic [7:0]  miso_byte = 8'hff;
    logic [7:0]  write_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  mosi_byte;
    logic        send_valid;
    logic        chip_select;
    logic        card_reset;
    logic        card_power;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        byte_taken;
    logic        done_res;
    logic        status;
    logic [7:0]  r1_response;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_BLOCK_ADDRESS;
    logic [31:0] cfg_data = 32'd0;

    int          fail_count;
    int          pending;
    logic        at_rest;
    logic        wants_tick;
    logic [7:0]  card_hint;
    logic        calm = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    sd_card_spi_host_sequencer uut (.*);

    sds_checker chk (.*);

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sd_card_spi_host_sequencer regression: fail");
            $finish;
        end
    end

    // hold the event until it is taken
    task automatic send_event(input logic [1:0] m, input logic [1:0] o,
                              input logic [7:0] mi, input logic [7:0] wb);
        in_valid <= 1'b1;
        mode <= m;
        op <= o;
        miso_byte <= mi;
        write_byte <= wb;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_events(input int count);
        int         pick;
        logic [1:0] m, o;
        logic [7:0] mi;
        for (int n = 0; n < count; n++)
        begin
            if (!calm && $urandom_range(0, 11) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            o = 2'($urandom_range(0, 2));
            mi = card_hint;
            if (pick < 8)
            begin
                m = 2'($urandom);
                o = 2'($urandom);
                mi = 8'($urandom);
            end
            else if (at_rest)
            begin
                m = MODE_REQUEST;
                if ($urandom_range(0, 9) == 0)
                    o = OP_NONE;
            end
            else if (wants_tick)
                m = MODE_TICK;
            else
            begin
                m = MODE_EXCHANGE;
                if (pick < 22)
                    mi = IDLE_BYTE;
                else if (pick < 30)
                    mi = 8'($urandom);
            end
            send_event(m, o, mi, 8'($urandom));
        end
    endtask

    task automatic load_regs(input logic [31:0] a, input logic [31:0] w,
                             input logic [31:0] p, input logic [31:0] s);
        write_reg(REG_BLOCK_ADDRESS, a);
        write_reg(REG_DATA_WAIT_LIMIT, w);
        write_reg(REG_RESET_PULSE_MS, p);
        write_reg(REG_POWER_SETTLE_MS, s);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored events, then a read with requests arriving while busy
        send_event(MODE_NONE, OP_WRITE, 8'h00, 8'hff);
        send_event(MODE_REQUEST, OP_NONE, 8'hff, 8'h00);
        send_event(MODE_EXCHANGE, OP_INIT, 8'h00, 8'hff);
        send_event(MODE_EXCHANGE, OP_READ, 8'hff, 8'h00);
        send_event(MODE_TICK, OP_INIT, 8'h5a, 8'ha5);
        send_event(MODE_REQUEST, OP_READ, 8'h00, 8'h00);
        send_event(MODE_REQUEST, OP_WRITE, 8'hff, 8'hff);
        send_event(MODE_REQUEST, OP_INIT, 8'h00, 8'h00);
        send_event(MODE_TICK, OP_READ, 8'hff, 8'hff);
        for (int k = 0; k < 9; k++)
            send_event(MODE_EXCHANGE, OP_READ, IDLE_BYTE, 8'h00);
        send_event(MODE_EXCHANGE, OP_READ, 8'h00, 8'hff);
        drain();

        run_events(250);
        drain();
        load_regs(32'h0000_0000, 32'd1, 32'd1, 32'd1);
        run_events(300);
        drain();
        load_regs(32'hffff_ffff, 32'd4095, 32'd255, 32'd1023);
        run_events(450);
        drain();
        load_regs(32'($urandom), 32'd0, 32'd0, 32'd0);
        run_events(300);
        drain();
        load_regs(32'($urandom), $urandom_range(1, 40), $urandom_range(1, 5),
                  $urandom_range(1, 8));
        calm <= 1'b1;
        run_events(300);
        drain();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("sd_card_spi_host_sequencer regression: pass");
        else
            $display("sd_card_spi_host_sequencer regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sds_pkg.sv
design/sd_card_spi_host_sequencer.sv
bench/sds_checker.sv
bench/tb.sv
